FILE: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants of the text pretokenizer chunker.
// ----------------------------------------------------------------------------
package tpc_pkg;

	// Default bound of the byte offset counter (offsets wrap past it).
	localparam longint unsigned TPC_MAX_TEXT_BYTES = 64'd65536;

	// Most chunk descriptors that one text byte can release.
	localparam int TPC_MAX_RES = 3;

	// Depth of the step queue between front and back.
	localparam int TPC_QUEUE_DEPTH = 4;

	// Fixed widths of the result fields.
	localparam int TPC_START_W  = 16;
	localparam int TPC_LENGTH_W = 17;

	// Control part of one step record: what one accepted byte released.
	typedef struct packed {
		logic       done;   // byte closed the text
		logic       ovf;    // offsets had wrapped when the byte arrived
		logic [1:0] cnt;    // number of chunks released, 0 to 3
	} tpc_step_ctl_t;

	localparam int TPC_CTL_W = $bits(tpc_step_ctl_t);

endpackage

FILE: rtl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// Byte classifier and chunk state machine; releases begin/end pairs per byte.
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; #(
	parameter longint unsigned MAX_TEXT_BYTES = TPC_MAX_TEXT_BYTES,
	localparam int PW = $clog2(MAX_TEXT_BYTES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [7:0]                       text_byte,
	input  logic                             end_of_text,
	output tpc_step_ctl_t                    ctl,
	output logic [TPC_MAX_RES-1:0][PW-1:0]   beg,
	output logic [TPC_MAX_RES-1:0][PW-1:0]   fin
);

	localparam logic [PW-1:0] LAST = PW'(MAX_TEXT_BYTES - 64'd1);

	// Chunk modes; the byte classes share the first codes.
	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_LETTER = 3'd1;
	localparam logic [2:0] MODE_DIGIT  = 3'd2;
	localparam logic [2:0] MODE_OTHER  = 3'd3;
	localparam logic [2:0] MODE_SPACE  = 3'd4;
	localparam logic [2:0] MODE_Q1     = 3'd5;
	localparam logic [2:0] MODE_Q2     = 3'd6;

	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UZ   = 8'h5A;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LZ   = 8'h7A;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_HI   = 8'h80;
	localparam logic [7:0] CH_S    = 8'h73;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_D    = 8'h64;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_V    = 8'h76;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_E    = 8'h65;

	function automatic logic [2:0] byte_class(input logic [7:0] b);
		logic [2:0] r;
		if ((b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ)) r = MODE_LETTER;
		else if (b >= CH_D0 && b <= CH_D9)                             r = MODE_DIGIT;
		else if (b == CH_SP || (b >= CH_TAB && b <= CH_CR))            r = MODE_SPACE;
		else if (b >= CH_HI)                                           r = MODE_LETTER;
		else                                                           r = MODE_OTHER;
		return r;
	endfunction

	logic [PW-1:0] pos_q;
	logic [PW-1:0] begin_q;
	logic [2:0]    mode_q;
	logic [7:0]    la1_q;
	logic          ovf_q;

	logic [2:0]    cls;
	logic [2:0]    start_mode;
	logic [PW-1:0] pinc, pdec, binc;
	logic [PW-1:0] nb;
	logic [2:0]    nm;
	logic [7:0]    nla;
	logic [1:0]    k;
	logic          run;
	logic [2:0]    rm;
	logic [7:0]    want;

	assign cls        = byte_class(text_byte);
	assign start_mode = (text_byte == CH_APOS) ? MODE_Q1 : cls;
	assign pinc       = (pos_q == LAST) ? '0 : pos_q + 1'b1;
	assign pdec       = (pos_q == '0) ? LAST : pos_q - 1'b1;
	assign binc       = (begin_q == LAST) ? '0 : begin_q + 1'b1;
	assign want       = (la1_q == CH_L) ? CH_L : CH_E;

	always_comb begin
		nb  = begin_q;
		nm  = mode_q;
		nla = la1_q;
		k   = 2'd0;
		run = 1'b0;
		rm  = MODE_NONE;
		beg = '0;
		fin = '0;

		unique case (mode_q) inside
			MODE_LETTER, MODE_DIGIT, MODE_OTHER: begin
				run = 1'b1;
				rm  = mode_q;
			end
			MODE_SPACE: begin
				if (cls != MODE_SPACE) begin
					// last blank heads the next chunk; drop an empty run
					if (begin_q != pdec) begin
						beg[k] = begin_q;
						fin[k] = pdec;
						k      = k + 2'd1;
					end
					nm = cls;
					nb = pdec;
				end
			end
			MODE_Q1: begin
				if (text_byte == CH_S || text_byte == CH_T ||
				    text_byte == CH_M || text_byte == CH_D) begin
					beg[k] = begin_q;
					fin[k] = pinc;
					k      = k + 2'd1;
					nm     = MODE_NONE;
				end else if (text_byte == CH_R || text_byte == CH_V ||
				             text_byte == CH_L) begin
					nla = text_byte;
					nm  = MODE_Q2;
				end else begin
					nm  = MODE_OTHER;
					run = 1'b1;
					rm  = MODE_OTHER;
				end
			end
			MODE_Q2: begin
				if (text_byte == want) begin
					beg[k] = begin_q;
					fin[k] = pinc;
					k      = k + 2'd1;
					nm     = MODE_NONE;
				end else begin
					// apostrophe alone, held letter opens a letter run
					beg[k] = begin_q;
					fin[k] = binc;
					k      = k + 2'd1;
					nb     = binc;
					nm     = MODE_LETTER;
					run    = 1'b1;
					rm     = MODE_LETTER;
				end
			end
			default: begin
				nb = pos_q;
				nm = start_mode;
			end
		endcase

		if (run && cls != rm) begin
			beg[k] = nb;
			fin[k] = pos_q;
			k      = k + 2'd1;
			nb     = pos_q;
			nm     = start_mode;
		end

		if (end_of_text) begin
			case (nm) inside
				MODE_LETTER, MODE_DIGIT, MODE_OTHER, MODE_SPACE, MODE_Q1: begin
					if (k != 2'd3) begin
						beg[k] = nb;
						fin[k] = pinc;
						k      = k + 2'd1;
					end
				end
				MODE_Q2: begin
					if (k != 2'd3) begin
						beg[k] = begin_q;
						fin[k] = binc;
						k      = k + 2'd1;
					end
					if (k != 2'd3) begin
						beg[k] = binc;
						fin[k] = pinc;
						k      = k + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end

		ctl.done = end_of_text;
		ctl.ovf  = ovf_q;
		ctl.cnt  = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			begin_q <= '0;
			mode_q  <= MODE_NONE;
			la1_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q   <= '0;
				begin_q <= '0;
				mode_q  <= MODE_NONE;
				la1_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				pos_q   <= pinc;
				begin_q <= nb;
				mode_q  <= nm;
				la1_q   <= nla;
				if (pos_q == LAST) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/tpc_queue.sv
// ----------------------------------------------------------------------------
// tpc_queue
// Small register queue of step records between front and back.
// ----------------------------------------------------------------------------
module tpc_queue import tpc_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = TPC_QUEUE_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// Serializes step records into chunk descriptors, one per cycle while chunk_stall is low.
// ----------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; #(
	parameter longint unsigned MAX_TEXT_BYTES = TPC_MAX_TEXT_BYTES,
	localparam int PW = $clog2(MAX_TEXT_BYTES)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  tpc_step_ctl_t                   ctl,
	input  logic [TPC_MAX_RES-1:0][PW-1:0]  beg,
	input  logic [TPC_MAX_RES-1:0][PW-1:0]  fin,
	output logic                            q_pop,
	output logic                            chunk_valid,
	input  logic                            chunk_stall,
	output logic [TPC_START_W-1:0]          chunk_start,
	output logic [TPC_LENGTH_W-1:0]         chunk_length,
	output logic                            text_done,
	output logic                            run_last,
	output logic                            position_overflow
);

	localparam logic [PW:0] BOUND = (PW+1)'(MAX_TEXT_BYTES);
	localparam int SW = (PW > TPC_START_W) ? PW : TPC_START_W;
	localparam int LW = (PW + 1 > TPC_LENGTH_W) ? PW + 1 : TPC_LENGTH_W;

	logic [1:0]    idx_q;
	logic          valid_q;
	logic          load;
	logic          last;
	logic [PW-1:0] b, e;
	logic [PW:0]   len;
	logic [SW-1:0] start_x;
	logic [LW-1:0] len_x;

	assign load  = !q_empty && (!valid_q || !chunk_stall);
	assign last  = (idx_q == 2'(ctl.cnt - 2'd1));
	assign q_pop = load && last;
	assign b     = beg[idx_q];
	assign e     = fin[idx_q];

	// equal ends mean a full wrap of the offset range
	assign len     = (e > b) ? {1'b0, e} - {1'b0, b} : BOUND - {1'b0, b} + {1'b0, e};
	assign start_x = SW'(b);
	assign len_x   = LW'(len);

	assign chunk_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			valid_q <= load || (valid_q && chunk_stall);
			if (load) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chunk_start       <= start_x[TPC_START_W-1:0];
			chunk_length      <= len_x[TPC_LENGTH_W-1:0];
			run_last          <= last;
			text_done         <= last && ctl.done;
			position_overflow <= ctl.ovf;
		end
	end

endmodule

FILE: rtl/text_pretokenizer_chunker_core.sv
// ----------------------------------------------------------------------------
// text_pretokenizer_chunker_core
// Splits a text byte stream into pre-token chunk descriptors (start, length).
// ----------------------------------------------------------------------------
//
//  channel  handshake                 payload
//  -------  ------------------------  -------------------------------------
//  byte     byte_valid / byte_stall   text_byte, end_of_text
//  chunk    chunk_valid / chunk_stall chunk_start, chunk_length, text_done,
//                                     run_last, position_overflow
//
//  The front takes one byte per cycle while the step queue has room; a byte
//  is classified and its chunk state advanced in the cycle of its transfer.
//  The back delivers one chunk per cycle from a registered output while
//  chunk_stall is low, so a byte that releases n chunks (0 to 3) holds the
//  back until all n are out; the four-entry step queue absorbs such bursts.
//  Reset clears control state at once, not data; no clearing pass follows.
//  byte_stall rises only when the step queue is full.
//
module text_pretokenizer_chunker_core import tpc_pkg::*; #(
	parameter longint unsigned MAX_TEXT_BYTES = TPC_MAX_TEXT_BYTES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [7:0]              text_byte,
	input  logic                    end_of_text,
	output logic                    chunk_valid,
	input  logic                    chunk_stall,
	output logic [TPC_START_W-1:0]  chunk_start,
	output logic [TPC_LENGTH_W-1:0] chunk_length,
	output logic                    text_done,
	output logic                    run_last,
	output logic                    position_overflow
);

	localparam int PW = $clog2(MAX_TEXT_BYTES);
	localparam int PAIRS_W = TPC_MAX_RES * PW;
	localparam int QW = TPC_CTL_W + 2 * PAIRS_W;

	logic                           accept;
	tpc_step_ctl_t                  f_ctl, b_ctl;
	logic [TPC_MAX_RES-1:0][PW-1:0] f_beg, f_fin, b_beg, b_fin;
	logic [QW-1:0]                  q_wr, q_rd;
	logic                           q_full, q_empty, q_pop;

	// Hold the byte side while the queue has no free slot.
	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;

	tpc_front #(
		.MAX_TEXT_BYTES (MAX_TEXT_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.ctl         (f_ctl),
		.beg         (f_beg),
		.fin         (f_fin)
	);

	// Drop bytes that release no chunk; only real steps enter the queue.
	assign q_wr = {f_ctl, f_beg, f_fin};

	tpc_queue #(
		.W     (QW),
		.DEPTH (TPC_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept && (f_ctl.cnt != 2'd0)),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign b_ctl = tpc_step_ctl_t'(q_rd[QW-1 -: TPC_CTL_W]);
	assign b_beg = q_rd[2*PAIRS_W-1 -: PAIRS_W];
	assign b_fin = q_rd[PAIRS_W-1:0];

	tpc_back #(
		.MAX_TEXT_BYTES (MAX_TEXT_BYTES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.ctl               (b_ctl),
		.beg               (b_beg),
		.fin               (b_fin),
		.q_pop             (q_pop),
		.chunk_valid       (chunk_valid),
		.chunk_stall       (chunk_stall),
		.chunk_start       (chunk_start),
		.chunk_length      (chunk_length),
		.text_done         (text_done),
		.run_last          (run_last),
		.position_overflow (position_overflow)
	);

endmodule
